>>> design/bjsd_pkg.sv
package bjsd_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int LOG_Q          = 28;
    localparam int WORK_Q         = 30;
    localparam int ROM_N          = (1 << LOG_TABLE_BITS) + 1;
    localparam int ROM_AW         = $clog2(ROM_N);
    localparam int REM_W          = WORK_Q - LOG_TABLE_BITS;
    localparam int NL_W           = 34;
    localparam int NLN_LAT        = 5;
    localparam int ENT_LAT        = NLN_LAT + 3;
    localparam int OUT_W          = 16;

    localparam logic [WORK_Q-1:0] LN2_Q30 = WORK_Q'(744261118);
    localparam logic [OUT_W-1:0]  LN2_CODE =
        OUT_W'((744261118 + (1 << (WORK_Q - FRAC_BITS - 1))) >> (WORK_Q - FRAC_BITS));

    typedef logic [LOG_Q:0] t_l2;
    typedef t_l2 t_rom [ROM_N];

    function automatic t_l2 rom_log2(int unsigned i);
        logic [63:0] z;
        t_l2         r;
        r = '0;
        if (i >= (1 << LOG_TABLE_BITS)) begin
            r[LOG_Q] = 1'b1;
            return r;
        end
        z = 64'((1 << LOG_TABLE_BITS) + i) << (WORK_Q - LOG_TABLE_BITS);
        for (int k = LOG_Q - 1; k >= 0; k--) begin
            z = (z * z) >> WORK_Q;
            if (z >= (64'd2 << WORK_Q)) begin
                z    = z >> 1;
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_rom build_rom();
        t_rom tab;
        for (int i = 0; i < ROM_N; i++) begin
            tab[i] = rom_log2(i);
        end
        return tab;
    endfunction

    localparam t_rom LOG_ROM = build_rom();

endpackage

>>> design/bjsd_nln.sv
module bjsd_nln #(
    parameter int FB = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [FB-1:0]             i_x,
    output logic [bjsd_pkg::NL_W-1:0] o_nln
);
    import bjsd_pkg::*;

    localparam int EW = $clog2(FB);
    localparam int MW = LOG_Q + REM_W + 1;
    localparam int LW = NL_W + WORK_Q;

    logic [EW-1:0]             w_e;
    logic [FB-1:0]             w_xm;
    logic [WORK_Q-1:0]         w_fr;
    logic [5:0]                w_sh;
    logic [MW-1:0]             w_mul;
    logic [LW-1:0]             w_ln;

    logic [EW-1:0]             r1_e, r2_e, r3_e;
    logic [LOG_TABLE_BITS-1:0] r1_idx;
    logic [REM_W-1:0]          r1_rem, r2_rem;
    t_l2                       r2_lo, r2_diff, r3_lo;
    logic [NL_W-1:0]           r3_prod, r4_nl, r5_nln;

    always_comb begin
        w_e = '0;
        for (int s = 0; s < FB; s++) begin
            if (i_x[s]) begin
                w_e = EW'(s);
            end
        end
    end

    assign w_xm  = i_x & ~(FB'(1) << w_e);
    assign w_sh  = 6'(WORK_Q) - 6'(w_e);
    assign w_fr  = WORK_Q'(64'(w_xm) << w_sh);
    assign w_mul = MW'(r2_diff) * MW'(r2_rem);
    assign w_ln  = LW'(r4_nl) * LW'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_e    <= w_e;
            r1_idx  <= w_fr[WORK_Q-1 -: LOG_TABLE_BITS];
            r1_rem  <= w_fr[REM_W-1:0];
            r2_e    <= r1_e;
            r2_rem  <= r1_rem;
            r2_lo   <= LOG_ROM[ROM_AW'(r1_idx)];
            r2_diff <= LOG_ROM[ROM_AW'(r1_idx) + ROM_AW'(1)] - LOG_ROM[ROM_AW'(r1_idx)];
            r3_e    <= r2_e;
            r3_lo   <= r2_lo;
            r3_prod <= NL_W'(w_mul >> REM_W);
            r4_nl   <= ((NL_W'(FB) - NL_W'(r3_e)) << LOG_Q) - NL_W'(r3_lo) - r3_prod;
            r5_nln  <= NL_W'(w_ln >> WORK_Q);
        end
    end

    assign o_nln = r5_nln;

endmodule

>>> design/bjsd_ent.sv
module bjsd_ent #(
    parameter int FB = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [FB:0]               i_x,
    output logic [bjsd_pkg::NL_W-1:0] o_h
);
    import bjsd_pkg::*;

    localparam int PW = FB + NL_W;

    logic [FB-1:0]   r_x, r_q;
    logic            r_z;
    logic [FB-1:0]   r_xd [NLN_LAT];
    logic [FB-1:0]   r_qd [NLN_LAT];
    logic            r_zd [NLN_LAT];
    logic [NL_W-1:0] w_nlx, w_nlq;
    logic [PW-1:0]   w_px, w_pq;
    logic [NL_W-1:0] r_tx, r_tq, r_h;
    logic            r_z1;

    bjsd_nln #(.FB(FB)) u_nln_x (.i_clk(i_clk), .i_en(i_en), .i_x(r_x), .o_nln(w_nlx));
    bjsd_nln #(.FB(FB)) u_nln_q (.i_clk(i_clk), .i_en(i_en), .i_x(r_q), .o_nln(w_nlq));

    assign w_px = PW'(r_xd[NLN_LAT-1]) * PW'(w_nlx);
    assign w_pq = PW'(r_qd[NLN_LAT-1]) * PW'(w_nlq);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= i_x[FB-1:0];
            r_q <= FB'((FB+1)'(1) << FB) - i_x[FB-1:0];
            r_z <= (i_x == '0) || i_x[FB];
            r_xd[0] <= r_x;
            r_qd[0] <= r_q;
            r_zd[0] <= r_z;
            for (int i = 1; i < NLN_LAT; i++) begin
                r_xd[i] <= r_xd[i-1];
                r_qd[i] <= r_qd[i-1];
                r_zd[i] <= r_zd[i-1];
            end
            r_tx <= NL_W'(w_px >> FB);
            r_tq <= NL_W'(w_pq >> FB);
            r_z1 <= r_zd[NLN_LAT-1];
            r_h  <= r_z1 ? '0 : r_tx + r_tq;
        end
    end

    assign o_h = r_h;

endmodule

>>> design/bernoulli_jsd_loss_top.sv
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// The pipeline depth is set by the log table read, the interpolation multiply,
// the ln2 scaling multiply and the entropy term multiply.
// Reset (synchronous, active low) clears only the valid bits; no other state.
module bernoulli_jsd_loss_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [16:0]                 i_predicted_prob,
    input  logic [16:0]                 i_target_prob,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bjsd_pkg::OUT_W-1:0]  o_jsd_loss
);
    import bjsd_pkg::*;

    localparam int LAT = ENT_LAT + 3;
    localparam int FB  = FRAC_BITS;
    localparam int RND = LOG_Q - FRAC_BITS;

    logic                    w_en;
    logic [LAT-1:0]          r_vld;
    logic [FB:0]             r_p, r_t, w_p, w_t;
    logic [FB+1:0]           r_s;
    logic [NL_W-1:0]         w_hp, w_ht, w_hs;
    logic [NL_W:0]           w_half;
    logic signed [NL_W+1:0]  r_d;
    logic [NL_W+1:0]         w_v;
    logic [OUT_W-1:0]        r_loss;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];
    assign o_jsd_loss = r_loss;

    assign w_p = (i_predicted_prob > (FB+1)'(1 << FB)) ? (FB+1)'(1 << FB) : i_predicted_prob;
    assign w_t = (i_target_prob > (FB+1)'(1 << FB)) ? (FB+1)'(1 << FB) : i_target_prob;

    bjsd_ent #(.FB(FB))     u_ent_p (.i_clk(i_clk), .i_en(w_en), .i_x(r_p), .o_h(w_hp));
    bjsd_ent #(.FB(FB))     u_ent_t (.i_clk(i_clk), .i_en(w_en), .i_x(r_t), .o_h(w_ht));
    bjsd_ent #(.FB(FB + 1)) u_ent_s (.i_clk(i_clk), .i_en(w_en), .i_x(r_s), .o_h(w_hs));

    assign w_half = ((NL_W+1)'(w_hp) + (NL_W+1)'(w_ht)) >> 1;
    assign w_v    = (NL_W+2)'(r_d + (NL_W+2)'(1 << (RND - 1))) >> RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p <= w_p;
            r_t <= w_t;
            r_s <= (FB+2)'(w_p) + (FB+2)'(w_t);
            r_d <= $signed({2'b00, w_hs}) - $signed({1'b0, w_half});
            if (r_d < 0) begin
                r_loss <= '0;
            end else if (w_v > (NL_W+2)'(LN2_CODE)) begin
                r_loss <= LN2_CODE;
            end else begin
                r_loss <= OUT_W'(w_v);
            end
        end
    end

    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_jsd_loss <= LN2_CODE)
        else $error("loss above ln2 code");
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without pending word");
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved while frozen");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vld == '0)
        else $error("valid bits not cleared by reset");

endmodule

>>> tb/sv/bernoulli_jsd_loss_top_test.sv
`timescale 1ns / 100ps

module bernoulli_jsd_loss_top_test;

    localparam int ONE_CODE = 1 << bjsd_pkg::FRAC_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [16:0] i_predicted_prob;
    logic [16:0] i_target_prob;
    logic        o_valid;
    logic        i_stall;
    logic [bjsd_pkg::OUT_W-1:0] o_jsd_loss;

    logic [bjsd_pkg::OUT_W-1:0] loss_queue[$];
    int  error_count;
    int  cycle_count;
    bit  stall_enable;

    bernoulli_jsd_loss_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_predicted_prob (i_predicted_prob),
        .i_target_prob    (i_target_prob),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_jsd_loss       (o_jsd_loss)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] log2_entry(longint unsigned i);
        logic [63:0] z;
        logic [63:0] r;
        r = 0;
        if (i >= (1 << bjsd_pkg::LOG_TABLE_BITS)) begin
            return 64'd1 << bjsd_pkg::LOG_Q;
        end
        z = ((64'd1 << bjsd_pkg::LOG_TABLE_BITS) + i)
            << (bjsd_pkg::WORK_Q - bjsd_pkg::LOG_TABLE_BITS);
        for (int k = bjsd_pkg::LOG_Q - 1; k >= 0; k--) begin
            z = (z * z) >> bjsd_pkg::WORK_Q;
            if (z >= (64'd2 << bjsd_pkg::WORK_Q)) begin
                z = z >> 1;
                r[k] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] minus_ln(logic [63:0] x, int f);
        int          e;
        int          sh;
        logic [63:0] frac;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] l2;
        logic [63:0] nl;
        e = 0;
        for (int s = f - 1; s >= 0; s--) begin
            if (x[s]) begin
                e = s;
                break;
            end
        end
        sh = bjsd_pkg::WORK_Q - bjsd_pkg::LOG_TABLE_BITS;
        frac = (x - (64'd1 << e)) << (bjsd_pkg::WORK_Q - e);
        idx = frac >> sh;
        rem = frac & ((64'd1 << sh) - 1);
        lo = log2_entry(idx);
        hi = log2_entry(idx + 1);
        l2 = (64'(e) << bjsd_pkg::LOG_Q) + lo + (((hi - lo) * rem) >> sh);
        nl = (64'(f) << bjsd_pkg::LOG_Q) - l2;
        return (nl * 64'd744261118) >> bjsd_pkg::WORK_Q;
    endfunction

    function automatic logic [63:0] binary_entropy(logic [63:0] x, int f);
        logic [63:0] one;
        logic [63:0] q;
        one = 64'd1 << f;
        if (x == 0 || x >= one) begin
            return 0;
        end
        q = one - x;
        return ((x * minus_ln(x, f)) >> f) + ((q * minus_ln(q, f)) >> f);
    endfunction

    function automatic logic [bjsd_pkg::OUT_W-1:0] jsd_of(logic [16:0] pred,
                                                          logic [16:0] tgt);
        logic [63:0] p;
        logic [63:0] t;
        longint      d;
        logic [63:0] v;
        p = (pred > ONE_CODE) ? 64'(ONE_CODE) : 64'(pred);
        t = (tgt > ONE_CODE) ? 64'(ONE_CODE) : 64'(tgt);
        d = longint'(binary_entropy(p + t, bjsd_pkg::FRAC_BITS + 1))
            - longint'((binary_entropy(p, bjsd_pkg::FRAC_BITS)
                        + binary_entropy(t, bjsd_pkg::FRAC_BITS)) >> 1);
        if (d < 0) begin
            d = 0;
        end
        v = (64'(d) + (64'd1 << (bjsd_pkg::LOG_Q - bjsd_pkg::FRAC_BITS - 1)))
            >> (bjsd_pkg::LOG_Q - bjsd_pkg::FRAC_BITS);
        if (v > 64'(bjsd_pkg::LN2_CODE)) begin
            v = 64'(bjsd_pkg::LN2_CODE);
        end
        return v[bjsd_pkg::OUT_W-1:0];
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_pair(logic [16:0] pred, logic [16:0] tgt);
        i_predicted_prob <= pred;
        i_target_prob <= tgt;
        i_valid <= 1'b1;
        loss_queue.push_back(jsd_of(pred, tgt));
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        if (stall_enable) begin
            int g;
            g = gap_length();
            if (g > 0) begin
                i_valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
    endtask

    function automatic logic [16:0] random_prob();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 17'($urandom_range(0, 16));
        end else if (r == 1) begin
            return 17'(ONE_CODE - $urandom_range(0, 16));
        end else if (r == 2) begin
            return 17'($urandom_range(0, 131071));
        end
        return 17'($urandom_range(0, ONE_CODE));
    endfunction

    task automatic test_extremes();
        stall_enable = 1'b0;
        send_pair(17'd0, 17'd0);
        send_pair(17'(ONE_CODE), 17'(ONE_CODE));
        send_pair(17'd0, 17'(ONE_CODE));
        send_pair(17'(ONE_CODE), 17'd0);
        send_pair(17'd1, 17'd0);
        send_pair(17'(ONE_CODE - 1), 17'd1);
        send_pair(17'h1FFFF, 17'd0);
        send_pair(17'h1FFFF, 17'h1FFFF);
        send_pair(17'h10001, 17'd32768);
        send_pair(17'd32768, 17'd32768);
        send_pair(17'd32768, 17'd32769);
        send_pair(17'd1, 17'd1);
        send_pair(17'd1, 17'd2);
        send_pair(17'd12345, 17'd54321);
        send_pair(17'h0AAAA, 17'h15555);
        send_pair(17'h15555, 17'h0AAAA);
    endtask

    task automatic test_random_pairs();
        stall_enable = 1'b1;
        for (int n = 0; n < 450; n++) begin
            if (n == 150) begin
                stall_enable = 1'b0;
            end else if (n == 200) begin
                stall_enable = 1'b1;
            end
            send_pair(random_prob(), random_prob());
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        int r;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (cycle_count > 2000 && cycle_count < 2300) begin
                i_stall <= 1'b0;
            end else if (r < 8) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(5, 25)) @(negedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= (r < 30);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (loss_queue.size() == 0) begin
                $display("%0t: unexpected result word, actual jsd_loss %0d",
                         $time, o_jsd_loss);
                error_count++;
            end else begin
                logic [bjsd_pkg::OUT_W-1:0] want;
                want = loss_queue.pop_front();
                if (want !== o_jsd_loss) begin
                    $display("%0t: jsd_loss mismatch, expected %0d actual %0d",
                             $time, want, o_jsd_loss);
                    error_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        cycle_count = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_predicted_prob = '0;
        i_target_prob = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_random_pairs();
        while (loss_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
